@@ hw/rtl/rgb_to_ihls_pixel_macros.svh @@
// Assertion macros shared by the RGB to IHLS pixel converter.
`ifndef RGB_TO_IHLS_PIXEL_MACROS_SVH
`define RGB_TO_IHLS_PIXEL_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IHLS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ihls check failed");

// Next-cycle implication, checked outside reset.
`define IHLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ihls check failed");

`endif

@@ hw/rtl/ihls_pkg.sv @@
// Types, constants and angle table for the RGB to IHLS pixel converter.
package ihls_pkg;

   localparam int TABLE_LEN          = 24;
   localparam int ANGLE_STAGES_DEF   = 16;
   localparam int CORDIC_W           = 26;
   localparam int PROD_W             = 24;

   localparam logic [15:0] W_RED     = 16'd13933;
   localparam logic [15:0] W_GREEN   = 16'd46871;
   localparam logic [15:0] W_BLUE    = 16'd4732;
   localparam logic [15:0] SQRT3_Q14 = 16'd28378;

   localparam logic signed [CORDIC_W-1:0] DEG90_Q16  = 26'sd5898240;
   localparam logic signed [CORDIC_W-1:0] DEG180_Q16 = 26'sd11796480;
   localparam logic signed [CORDIC_W-1:0] DEG360_Q16 = 26'sd23592960;

   localparam logic [7:0] HUE_ZERO = 8'd0;
   localparam logic [7:0] HUE_NINETY = 8'd90;

   // atan(2^-i) in degrees, Q16
   localparam logic signed [CORDIC_W-1:0] ATAN_DEG_Q16 [TABLE_LEN] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945, 26'sd234379, 26'sd117304,
      26'sd58666, 26'sd29335, 26'sd14668, 26'sd7334, 26'sd3667, 26'sd1833,
      26'sd917, 26'sd458, 26'sd229, 26'sd115, 26'sd57, 26'sd29,
      26'sd14, 26'sd7, 26'sd4, 26'sd2, 26'sd1, 26'sd0
   };

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [7:0] hue_half_deg;
      logic [7:0] luma;
      logic [7:0] chroma_span;
   } rsp_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic signed [CORDIC_W-1:0] z;
   } vec_type;

   // Data that rides along the rotation chain unchanged
   typedef struct packed {
      logic              flat;      // green equals blue, angle known exactly
      logic              flat_neg;  // 2R < G+B in the flat case
      logic              b_gt_g;
      logic [7:0]        span;
      logic [PROD_W-1:0] prod_r;
      logic [PROD_W-1:0] prod_g;
      logic [PROD_W-1:0] prod_b;
   } side_type;

endpackage

@@ hw/rtl/rgb_to_ihls_pixel.sv @@
// RGB to IHLS pixel converter, top level.
// Pipeline: setup stage, one cell per rotation, output stage.
// Throughput: one pixel per cycle; busy is never raised and results cannot be held off.
// The rate is set by the rotation chain, which advances every cycle.
// Reset (synchronous) clears the pipeline valid bits; pixels in flight are dropped.
module rgb_to_ihls_pixel import ihls_pkg::*; #(
   parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_pixel,
   output logic    rsp_strobe,
   output rsp_type rsp_pixel
);

`include "rgb_to_ihls_pixel_macros.svh"

   localparam int LATENCY = ANGLE_STAGES + 2;

   logic     chain_valid [ANGLE_STAGES+1];
   vec_type  chain_vec   [ANGLE_STAGES+1];
   side_type chain_side  [ANGLE_STAGES+1];
   logic     accept;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   ihls_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_pixel  (req_pixel),
      .out_valid (chain_valid[0]),
      .out_vec   (chain_vec[0]),
      .out_side  (chain_side[0])
   );

   for (genvar i = 0; i < ANGLE_STAGES; i++) begin : g_cell
      ihls_cell #(.STAGE(i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_vec    (chain_vec[i]),
         .in_side   (chain_side[i]),
         .out_valid (chain_valid[i+1]),
         .out_vec   (chain_vec[i+1]),
         .out_side  (chain_side[i+1])
      );
   end

   ihls_finish #(.ANGLE_STAGES(ANGLE_STAGES)) u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[ANGLE_STAGES]),
      .in_vec    (chain_vec[ANGLE_STAGES]),
      .in_side   (chain_side[ANGLE_STAGES]),
      .out_valid (rsp_strobe),
      .out_pixel (rsp_pixel)
   );

   // every result traces back to an earlier transfer that passed through the whole pipeline
   `IHLS_ASSERT_NOW(a_strobe_origin, clock, reset, rsp_strobe, $past(start, LATENCY))
   `IHLS_ASSERT_NOW(a_hue_range, clock, reset, rsp_strobe, rsp_pixel.hue_half_deg <= 8'd180)
   // zero span means a gray pixel, whose hue is forced to zero
   `IHLS_ASSERT_NOW(a_gray_hue, clock, reset,
      rsp_strobe && (rsp_pixel.chroma_span == 8'd0), rsp_pixel.hue_half_deg == HUE_ZERO)
   `IHLS_ASSERT_NEXT(a_never_busy, clock, reset, 1'b1, !busy)

endmodule

@@ hw/rtl/ihls_prep.sv @@
// Input stage: chroma vector setup, quadrant turn, luma products and channel span.
module ihls_prep import ihls_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_pixel,
   output logic     out_valid,
   output vec_type  out_vec,
   output side_type out_side
);

   logic                       valid_ff;
   vec_type                    vec_ff, vec_in;
   side_type                   side_ff, side_in;
   logic signed [9:0]          xc;
   logic [7:0]                 diff;
   logic signed [CORDIC_W-1:0] x0;
   logic signed [CORDIC_W-1:0] y0;
   logic [7:0]                 mx, mn;

   always_comb begin
      xc   = $signed({1'b0, in_pixel.red, 1'b0}) - $signed({2'b00, in_pixel.green})
             - $signed({2'b00, in_pixel.blue});
      diff = (in_pixel.green > in_pixel.blue) ? in_pixel.green - in_pixel.blue
                                              : in_pixel.blue - in_pixel.green;
      x0   = {{2{xc[9]}}, xc, 14'b0};
      y0   = $signed(CORDIC_W'(diff) * CORDIC_W'(SQRT3_Q14));

      // negative x: turn by -90 degrees so the chain sees the right half plane
      if (xc[9]) begin
         vec_in.x = y0;
         vec_in.y = -x0;
         vec_in.z = DEG90_Q16;
      end else begin
         vec_in.x = x0;
         vec_in.y = y0;
         vec_in.z = '0;
      end

      mx = in_pixel.red;
      if (in_pixel.green > mx) mx = in_pixel.green;
      if (in_pixel.blue > mx) mx = in_pixel.blue;
      mn = in_pixel.red;
      if (in_pixel.green < mn) mn = in_pixel.green;
      if (in_pixel.blue < mn) mn = in_pixel.blue;

      side_in.flat     = (in_pixel.green == in_pixel.blue);
      side_in.flat_neg = xc[9];
      side_in.b_gt_g   = (in_pixel.blue > in_pixel.green);
      side_in.span     = mx - mn;
      side_in.prod_r   = PROD_W'(in_pixel.red) * PROD_W'(W_RED);
      side_in.prod_g   = PROD_W'(in_pixel.green) * PROD_W'(W_GREEN);
      side_in.prod_b   = PROD_W'(in_pixel.blue) * PROD_W'(W_BLUE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      side_ff <= side_in;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

@@ hw/rtl/ihls_cell.sv @@
// One vectoring rotation cell of the angle chain.
module ihls_cell import ihls_pkg::*; #(
   parameter int STAGE = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  vec_type  in_vec,
   input  side_type in_side,
   output logic     out_valid,
   output vec_type  out_vec,
   output side_type out_side
);

   logic                       valid_ff;
   vec_type                    vec_ff, vec_in;
   side_type                   side_ff;
   logic signed [CORDIC_W-1:0] dx, dy;

   always_comb begin
      // arithmetic shift floors, as required
      dx = in_vec.y >>> STAGE;
      dy = in_vec.x >>> STAGE;
      if (!in_vec.y[CORDIC_W-1]) begin
         vec_in.x = in_vec.x + dx;
         vec_in.y = in_vec.y - dy;
         vec_in.z = in_vec.z + ATAN_DEG_Q16[STAGE];
      end else begin
         vec_in.x = in_vec.x - dx;
         vec_in.y = in_vec.y + dy;
         vec_in.z = in_vec.z - ATAN_DEG_Q16[STAGE];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff  <= vec_in;
      side_ff <= in_side;
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

@@ hw/rtl/ihls_finish.sv @@
// Output stage: angle bias and clamp, hue fold, luma sum.
module ihls_finish import ihls_pkg::*; #(
   parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  vec_type  in_vec,
   input  side_type in_side,
   output logic     out_valid,
   output rsp_type  out_pixel
);

   localparam logic signed [CORDIC_W-1:0] BIAS = ATAN_DEG_Q16[ANGLE_STAGES-1] + 26'sd4;

   logic                       valid_ff;
   rsp_type                    pixel_ff, pixel_in;
   logic signed [CORDIC_W-1:0] z_b, z_c, hue_q;
   logic [PROD_W-1:0]          lum_sum;

   always_comb begin
      z_b = in_vec.z + BIAS;
      priority if (z_b[CORDIC_W-1]) begin
         z_c = '0;
      end else if (z_b > DEG180_Q16) begin
         z_c = DEG180_Q16;
      end else begin
         z_c = z_b;
      end
      hue_q = in_side.b_gt_g ? (DEG360_Q16 - z_c) : z_c;

      if (in_side.flat) begin
         pixel_in.hue_half_deg = in_side.flat_neg ? HUE_NINETY : HUE_ZERO;
      end else begin
         pixel_in.hue_half_deg = hue_q[24:17];
      end

      lum_sum              = in_side.prod_r + in_side.prod_g + in_side.prod_b;
      pixel_in.luma        = lum_sum[PROD_W-1:PROD_W-8];
      pixel_in.chroma_span = in_side.span;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
   end

   assign out_valid = valid_ff;
   assign out_pixel = pixel_ff;

endmodule

@@ tb/sv/tb_rgb_to_ihls_pixel.sv @@
// Self-checking testbench for the RGB to IHLS pixel converter.
`timescale 1ns / 1ps

module tb_rgb_to_ihls_pixel;
   import ihls_pkg::*;

   localparam int ROT_STAGES = (ANGLE_STAGES_DEF > TABLE_LEN) ? TABLE_LEN : ANGLE_STAGES_DEF;
   localparam int DRAIN_CYCLES = ANGLE_STAGES_DEF + 20;
   localparam int RANDOM_PER_PHASE = 488;

   // Holds expected IHLS triples in transfer order and checks results against them
   class ihls_ledger;
      rsp_type expected_ihls[$];
      int      failures;

      function new();
         failures = 0;
      endfunction

      // Bit-exact IHLS conversion of one pixel
      static function rsp_type rgb_to_ihls(req_type p);
         longint r, g, b, xc, x, y, z, t, dx, dy, hue, mx, mn, lum;
         rsp_type res;
         r = p.red;
         g = p.green;
         b = p.blue;
         xc = 2 * r - g - b;
         if (g == b) begin
            // angle exactly 0 or 180, no rotation needed
            hue = (xc < 0) ? longint'(HUE_NINETY) : longint'(HUE_ZERO);
         end else begin
            x = xc * 16384;
            y = ((g > b) ? (g - b) : (b - g)) * longint'(SQRT3_Q14);
            z = 0;
            if (x < 0) begin
               t = x;
               x = y;
               y = -t;
               z = longint'(DEG90_Q16);
            end
            for (int i = 0; i < ROT_STAGES; i++) begin
               dx = y >>> i;
               dy = x >>> i;
               if (y >= 0) begin
                  x = x + dx;
                  y = y - dy;
                  z = z + longint'(ATAN_DEG_Q16[i]);
               end else begin
                  x = x - dx;
                  y = y + dy;
                  z = z - longint'(ATAN_DEG_Q16[i]);
               end
            end
            if (ROT_STAGES > 0)
               z = z + longint'(ATAN_DEG_Q16[ROT_STAGES-1]) + 4;
            if (z < 0)
               z = 0;
            if (z > longint'(DEG180_Q16))
               z = longint'(DEG180_Q16);
            if (b <= g)
               hue = z >>> 17;
            else
               hue = (longint'(DEG360_Q16) - z) >>> 17;
         end
         if (hue > 180)
            hue = 180;
         mx = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         mn = r;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         lum = (longint'(W_RED) * r + longint'(W_GREEN) * g + longint'(W_BLUE) * b) >>> 16;
         res.hue_half_deg = hue[7:0];
         res.luma         = lum[7:0];
         res.chroma_span  = mx[7:0] - mn[7:0];
         return res;
      endfunction

      function void note_pixel(req_type p);
         expected_ihls.insert(expected_ihls.size(), rgb_to_ihls(p));
      endfunction

      function void flag(string msg);
         failures++;
         if (failures <= 10)
            $display("MISMATCH @%0t: %s", $realtime, msg);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_ihls.size() == 0) begin
            flag($sformatf("unexpected result hue=%0d luma=%0d span=%0d",
                           got.hue_half_deg, got.luma, got.chroma_span));
            return;
         end
         want = expected_ihls.pop_front();
         if (got.hue_half_deg !== want.hue_half_deg || got.luma !== want.luma ||
             got.chroma_span !== want.chroma_span)
            flag($sformatf("exp hue=%0d luma=%0d span=%0d, got hue=%0d luma=%0d span=%0d",
                           want.hue_half_deg, want.luma, want.chroma_span,
                           got.hue_half_deg, got.luma, got.chroma_span));
      endfunction

      function int pending();
         return expected_ihls.size();
      endfunction

      function int close_out();
         if (expected_ihls.size() != 0)
            flag($sformatf("%0d expected results never arrived", expected_ihls.size()));
         return failures;
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_pixel;
   logic    rsp_strobe;
   rsp_type rsp_pixel;

   ihls_ledger board;

   rgb_to_ihls_pixel u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_pixel  (req_pixel),
      .rsp_strobe (rsp_strobe),
      .rsp_pixel  (rsp_pixel)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Transfers are observed at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            board.note_pixel(req_pixel);
         if (rsp_strobe)
            board.check_result(rsp_pixel);
      end
   end

   function automatic req_type pix(int r, int g, int b);
      req_type p;
      p.red   = r[7:0];
      p.green = g[7:0];
      p.blue  = b[7:0];
      return p;
   endfunction

   function automatic req_type random_pixel();
      int      kind, r, g, lo, hi, base;
      int      corner[4];
      req_type p;
      kind = $urandom_range(99, 0);
      corner = '{0, 1, 254, 255};
      p = req_type'(24'($urandom));
      if (kind < 15) begin
         // near gray: small chroma vectors stress the angle resolution
         base = $urandom_range(255, 0);
         p.red   = 8'(base + $urandom_range(3, 0));
         p.green = 8'(base + $urandom_range(3, 0));
         p.blue  = 8'(base + $urandom_range(3, 0));
      end else if (kind < 25) begin
         p.blue = p.green;
      end else if (kind < 35) begin
         // 2R = G + B puts the vector on the y axis
         r = $urandom_range(255, 0);
         lo = (2 * r > 255) ? 2 * r - 255 : 0;
         hi = (2 * r < 255) ? 2 * r : 255;
         g = $urandom_range(hi, lo);
         p = pix(r, g, 2 * r - g);
      end else if (kind < 40) begin
         p = pix(corner[$urandom_range(3, 0)], corner[$urandom_range(3, 0)],
                 corner[$urandom_range(3, 0)]);
      end
      return p;
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer
   task automatic send_pixel(input req_type p, input int idle_pct);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start     <= 1'b1;
      req_pixel <= p;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (board.pending() != 0)
         @(negedge clock);
   endtask

   initial begin
      req_type directed[$];
      int      idle_set[4];
      int      idle_pct;
      board = new();
      reset = 1'b1;
      start = 1'b0;
      req_pixel = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed = '{pix(0, 0, 0), pix(255, 255, 255), pix(128, 128, 128),
                   pix(255, 0, 0), pix(0, 255, 255), pix(10, 20, 20), pix(200, 100, 100),
                   pix(0, 255, 0), pix(0, 0, 255), pix(255, 255, 0), pix(255, 0, 255),
                   pix(100, 50, 51), pix(100, 51, 50), pix(1, 0, 0), pix(0, 1, 0),
                   pix(0, 0, 1), pix(254, 255, 255), pix(255, 254, 254),
                   pix(128, 255, 1), pix(127, 0, 254), pix(170, 85, 170), pix(85, 170, 85),
                   pix(0, 255, 254), pix(0, 254, 255)};
      foreach (directed[i])
         send_pixel(directed[i], 0);
      drain();

      // no idling, heavy sender gaps, light gaps, no idling again
      idle_set = '{0, 85, 15, 0};
      foreach (idle_set[ph]) begin
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            idle_pct = ((k % 64) < 16) ? 0 : idle_set[ph];
            send_pixel(random_pixel(), idle_pct);
         end
         drain();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (board.close_out() == 0)
         $display("tb_rgb_to_ihls_pixel: done, clean");
      else
         $display("tb_rgb_to_ihls_pixel: done, errors");
      $finish;
   end

   initial begin
      #3000000;
      $display("tb_rgb_to_ihls_pixel: done, errors");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/ihls_pkg.sv
hw/rtl/ihls_prep.sv
hw/rtl/ihls_cell.sv
hw/rtl/ihls_finish.sv
hw/rtl/rgb_to_ihls_pixel.sv
tb/sv/tb_rgb_to_ihls_pixel.sv
